// ===== design/ngga_pkg.sv =====
// Shared types, codes and constants for the GGA sentence field splitter.
package ngga_pkg;

    localparam int FIELD_W      = 4;
    localparam int LEN_W        = 4;
    localparam int HEADER_LEN   = 6;
    localparam int REPORT_CHARS = 10;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    // Work codes passed from the parser to the field store
    typedef enum logic [1:0] {
        OP_CHAR,
        OP_LEN,
        OP_EMIT
    } cmd_op_t;

    // pos holds the character position for OP_CHAR and the length otherwise
    typedef struct packed {
        cmd_op_t              op;
        logic [FIELD_W-1:0]   field;
        logic [LEN_W-1:0]     pos;
        logic [7:0]           data;
    } cmd_t;

    // Characters of "GPGGA," in order
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h47;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h41;
            3'd5:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/nmea_gga_field_splitter.sv =====
// Top level of the GGA sentence field splitter.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   input   | in        | in_valid / in_stall | rx_byte
//   output  | out       | out_valid/out_stall | field_number, field_length, chars_*,
//           |           |                     | last_field
//
// The parser takes one byte per cycle while the four-entry command queue has room.
// A finished sentence is reported one field at a time; each field is read out of the
// character store one character at a time and is then shown for as long as out_stall holds it.
// The queue fills and in_stall rises during a burst.
// Reset clears the parse state, the queue and the burst sequencer; the stores need no clear.
module nmea_gga_field_splitter
    import ngga_pkg::*;
#(
    parameter int NUM_FIELDS  = 9,
    parameter int FIELD_CHARS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  field_number,
    output logic [3:0]  field_length,
    output logic [31:0] chars_zero_to_three,
    output logic [31:0] chars_four_to_seven,
    output logic [15:0] chars_eight_nine,
    output logic        last_field
);

    logic q_full;
    logic push_valid;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;
    logic accept;

    // Stall input transactions while the queue is full
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    ngga_front #(
        .NUM_FIELDS  (NUM_FIELDS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    ngga_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop_ready  (pop_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    ngga_back #(
        .NUM_FIELDS  (NUM_FIELDS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .pop_valid           (pop_valid),
        .pop_cmd             (pop_cmd),
        .pop_ready           (pop_ready),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .field_number        (field_number),
        .field_length        (field_length),
        .chars_zero_to_three (chars_zero_to_three),
        .chars_four_to_seven (chars_four_to_seven),
        .chars_eight_nine    (chars_eight_nine),
        .last_field          (last_field)
    );

endmodule

// ===== design/ngga_front.sv =====
// Byte parser: hunts for the header, tracks fields and issues store commands.
module ngga_front
    import ngga_pkg::*;
#(
    parameter int NUM_FIELDS  = 9,
    parameter int FIELD_CHARS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       push_valid,
    output cmd_t       push_cmd
);

    localparam int FIW = $clog2(NUM_FIELDS);
    localparam int CW  = $clog2(FIELD_CHARS + 1);

    localparam logic [1:0] MODE_HUNT   = 2'd0;
    localparam logic [1:0] MODE_MATCH  = 2'd1;
    localparam logic [1:0] MODE_BUFFER = 2'd2;

    logic [1:0]     mode_reg, mode_next;
    logic [2:0]     match_reg, match_next;
    logic [FIW-1:0] field_reg, field_next;
    logic [CW-1:0]  char_reg, char_next;
    logic           hunt_check;

    // Classify the accepted byte and pick the next parse state
    always_comb
    begin
        mode_next  = mode_reg;
        match_next = match_reg;
        field_next = field_reg;
        char_next  = char_reg;
        hunt_check = 1'b0;
        push_valid = 1'b0;
        push_cmd   = '{op: OP_CHAR, field: FIELD_W'(field_reg), pos: LEN_W'(char_reg),
                       data: rx_byte};
        if (accept)
        begin
            priority if (mode_reg == MODE_MATCH)
            begin
                if (match_reg < 3'(HEADER_LEN) && rx_byte == header_char(match_reg))
                begin
                    match_next = match_reg + 3'd1;
                    if (match_reg == 3'(HEADER_LEN - 1))
                    begin
                        mode_next  = MODE_BUFFER;
                        field_next = '0;
                        char_next  = '0;
                    end
                end
                else
                begin
                    // recheck the failing byte as a possible start
                    hunt_check = 1'b1;
                end
            end
            else if (mode_reg == MODE_BUFFER)
            begin
                priority if (rx_byte == CHAR_DOLLAR)
                begin
                    mode_next = MODE_HUNT;
                end
                else if (rx_byte == CHAR_COMMA)
                begin
                    push_valid = 1'b1;
                    if (field_reg == FIW'(NUM_FIELDS - 1))
                    begin
                        push_cmd.op = OP_EMIT;
                        mode_next   = MODE_HUNT;
                    end
                    else
                    begin
                        push_cmd.op = OP_LEN;
                        field_next  = field_reg + 1'b1;
                        char_next   = '0;
                    end
                end
                else if (char_reg == CW'(FIELD_CHARS))
                begin
                    // field overflow: drop the sentence
                    mode_next = MODE_HUNT;
                end
                else
                begin
                    push_valid = 1'b1;
                    char_next  = char_reg + 1'b1;
                end
            end
            else
            begin
                hunt_check = 1'b1;
            end

            if (hunt_check)
            begin
                if (rx_byte == CHAR_DOLLAR)
                begin
                    mode_next  = MODE_MATCH;
                    match_next = '0;
                end
                else
                begin
                    mode_next = MODE_HUNT;
                end
            end
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HUNT;
            match_reg <= '0;
            field_reg <= '0;
            char_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            match_reg <= match_next;
            field_reg <= field_next;
            char_reg  <= char_next;
        end
    end

endmodule

// ===== design/ngga_queue.sv =====
// Short command queue between the parser and the field store.
module ngga_queue
    import ngga_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop_ready,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/ngga_back.sv =====
// Field store and burst sequencer: writes characters and lengths, reports fields.
module ngga_back
    import ngga_pkg::*;
#(
    parameter int NUM_FIELDS  = 9,
    parameter int FIELD_CHARS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  cmd_t        pop_cmd,
    output logic        pop_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  field_number,
    output logic [3:0]  field_length,
    output logic [31:0] chars_zero_to_three,
    output logic [31:0] chars_four_to_seven,
    output logic [15:0] chars_eight_nine,
    output logic        last_field
);

    localparam int FIW   = $clog2(NUM_FIELDS);
    localparam int CW    = $clog2(FIELD_CHARS + 1);
    localparam int DEPTH = NUM_FIELDS * FIELD_CHARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RC    = (FIELD_CHARS < REPORT_CHARS) ? FIELD_CHARS : REPORT_CHARS;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_LOAD  = 2'd1;
    localparam logic [1:0] B_DRAIN = 2'd2;
    localparam logic [1:0] B_SHOW  = 2'd3;

    logic [7:0]       store_mem [DEPTH];
    logic [LEN_W-1:0] len_mem [NUM_FIELDS];

    logic [1:0]       state_reg, state_next;
    logic [FIW-1:0]   efield_reg, efield_next;
    logic [CW-1:0]    k_reg, k_next;
    logic             rd_pend_reg;
    logic [CW-1:0]    rd_pos_reg;
    logic [7:0]       rd_data_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       char_buf_reg [REPORT_CHARS];
    logic [7:0]       shown [REPORT_CHARS];

    logic             do_pop;
    logic [FIW-1:0]   cmd_field;
    logic [AW-1:0]    wr_addr, rd_addr;

    assign pop_ready = (state_reg == B_IDLE);
    assign do_pop    = pop_valid && pop_ready;
    assign cmd_field = pop_cmd.field[FIW-1:0];
    assign wr_addr   = AW'(cmd_field * FIELD_CHARS) + AW'(pop_cmd.pos);
    assign rd_addr   = AW'(efield_reg * FIELD_CHARS) + AW'(k_reg);

    // Write characters and lengths, read one character per cycle
    always_ff @(posedge clk)
    begin
        if (do_pop && pop_cmd.op == OP_CHAR)
        begin
            store_mem[wr_addr] <= pop_cmd.data;
        end
        if (do_pop && (pop_cmd.op == OP_LEN || pop_cmd.op == OP_EMIT))
        begin
            len_mem[cmd_field] <= pop_cmd.pos;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Sequence the burst: load a field, then show it until taken
    always_comb
    begin
        state_next  = state_reg;
        efield_next = efield_reg;
        k_next      = k_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (do_pop && pop_cmd.op == OP_EMIT)
                begin
                    state_next  = B_LOAD;
                    efield_next = '0;
                    k_next      = '0;
                end
            end
            B_LOAD:
            begin
                if (k_reg == CW'(RC - 1))
                begin
                    state_next = B_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            B_DRAIN:
            begin
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (!out_stall)
                begin
                    if (efield_reg == FIW'(NUM_FIELDS - 1))
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next  = B_LOAD;
                        efield_next = efield_reg + 1'b1;
                        k_next      = '0;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            efield_reg  <= '0;
            k_reg       <= '0;
            rd_pend_reg <= 1'b0;
            rd_pos_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            efield_reg  <= efield_next;
            k_reg       <= k_next;
            rd_pend_reg <= (state_reg == B_LOAD);
            rd_pos_reg  <= k_reg;
        end
    end

    // Capture read data into the character buffer and latch the length
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < REPORT_CHARS; i++)
        begin
            if (i < RC && rd_pend_reg && rd_pos_reg == CW'(i))
            begin
                char_buf_reg[i] <= rd_data_reg;
            end
        end
        if (state_reg == B_DRAIN)
        begin
            len_reg <= len_mem[efield_reg];
        end
    end

    // Zero characters past the field length
    always_comb
    begin
        for (int i = 0; i < REPORT_CHARS; i++)
        begin
            shown[i] = (i < RC && 4'(i) < len_reg) ? char_buf_reg[i] : 8'h00;
        end
    end

    assign out_valid           = (state_reg == B_SHOW);
    assign field_number        = 4'(efield_reg);
    assign field_length        = len_reg;
    assign chars_zero_to_three = {shown[3], shown[2], shown[1], shown[0]};
    assign chars_four_to_seven = {shown[7], shown[6], shown[5], shown[4]};
    assign chars_eight_nine    = {shown[9], shown[8]};
    assign last_field          = (efield_reg == FIW'(NUM_FIELDS - 1));

endmodule

// ===== design/ngga_checker.sv =====
// Port-level checks for the GGA sentence field splitter, bound to the top level.
module ngga_checker
#(
    parameter int NUM_FIELDS  = 9,
    parameter int FIELD_CHARS = 10
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  field_number,
    input logic [3:0]  field_length,
    input logic [31:0] chars_zero_to_three,
    input logic [31:0] chars_four_to_seven,
    input logic [15:0] chars_eight_nine,
    input logic        last_field
);

    // A stalled input transaction holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
    else $error("stalled input byte changed");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(field_number)
            && $stable(field_length) && $stable(chars_zero_to_three)
            && $stable(chars_four_to_seven) && $stable(chars_eight_nine)
            && $stable(last_field))
    else $error("stalled result changed");

    // The last flag marks exactly the final field number, lengths stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_field == (field_number == 4'(NUM_FIELDS - 1)))
            && field_length <= 4'(FIELD_CHARS))
    else $error("last flag or field length out of range");

    // A taken non-final field advances the field number
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_field
            |=> field_number == $past(field_number) + 4'd1)
    else $error("field numbers out of order");

    // An empty field reports no characters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_length == 4'd0 |-> chars_zero_to_three == '0
            && chars_four_to_seven == '0 && chars_eight_nine == '0)
    else $error("empty field carries characters");

endmodule

bind nmea_gga_field_splitter ngga_checker #(
    .NUM_FIELDS  (NUM_FIELDS),
    .FIELD_CHARS (FIELD_CHARS)
) u_ngga_checker (.*);

// ===== sim/gga_checker.sv =====
// Checker for the GGA field splitter: predicts the field bursts and compares them.
`timescale 1ns / 100ps

module gga_checker
    import ngga_pkg::*;
#(
    parameter int NUM_FIELDS  = 9,
    parameter int FIELD_CHARS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  field_number,
    input  logic [3:0]  field_length,
    input  logic [31:0] chars_zero_to_three,
    input  logic [31:0] chars_four_to_seven,
    input  logic [15:0] chars_eight_nine,
    input  logic        last_field,
    output int unsigned fail_count,
    output int unsigned pending_count,
    output int unsigned predicted_count
);

    localparam logic [8*HEADER_LEN-1:0] GGA_TAG = "GPGGA,";
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_MATCH,
        MODE_BUFFER
    } gga_mode_t;

    typedef struct packed {
        logic [3:0]  number;
        logic [3:0]  length;
        logic [31:0] c0;
        logic [31:0] c4;
        logic [15:0] c8;
        logic        last;
    } gga_field_t;

    // Shadow copy of the sentence parser
    gga_mode_t   mode = MODE_HUNT;
    int unsigned tag_pos = 0;
    logic [3:0]  cur_field = '0;
    logic [3:0]  cur_char = '0;
    logic [7:0]  text_store [NUM_FIELDS][FIELD_CHARS];
    logic [3:0]  text_len [NUM_FIELDS];

    gga_field_t  expected_fields [$];
    int unsigned mismatches = 0;
    int unsigned predicted_total = 0;
    gga_field_t  got;
    gga_field_t  want;

    assign fail_count = mismatches;

    // Advance the shadow parser by one byte and queue a burst on the last comma
    task automatic split_byte(input logic [7:0] b);
        logic [79:0] text;
        gga_field_t  entry;
        if (mode == MODE_MATCH) begin
            if (tag_pos < HEADER_LEN && b == GGA_TAG[8*(HEADER_LEN-1-tag_pos) +: 8]) begin
                tag_pos++;
                if (tag_pos == HEADER_LEN) begin
                    mode      = MODE_BUFFER;
                    cur_field = '0;
                    cur_char  = '0;
                end
                return;
            end
            // failing byte gets another look as a possible start
            mode = MODE_HUNT;
        end
        if (mode == MODE_BUFFER) begin
            if (b == CHAR_DOLLAR) begin
                mode = MODE_HUNT;
            end
            else if (b == CHAR_COMMA) begin
                text_len[cur_field] = cur_char;
                if (cur_field == NUM_FIELDS - 1) begin
                    mode = MODE_HUNT;
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        text = '0;
                        for (int k = 0; k < REPORT_CHARS; k++) begin
                            if (k < FIELD_CHARS && k < text_len[f])
                                text[8*k +: 8] = text_store[f][k];
                        end
                        entry.number = f[3:0];
                        entry.length = text_len[f];
                        entry.c0     = text[31:0];
                        entry.c4     = text[63:32];
                        entry.c8     = text[79:64];
                        entry.last   = (f == NUM_FIELDS - 1);
                        expected_fields.push_back(entry);
                        predicted_total++;
                    end
                end
                else begin
                    cur_field = cur_field + 1'b1;
                    cur_char  = '0;
                end
            end
            else if (cur_char == FIELD_CHARS) begin
                // field overflow drops the sentence
                mode = MODE_HUNT;
            end
            else begin
                text_store[cur_field][cur_char] = b;
                cur_char = cur_char + 1'b1;
            end
        end
        else if (b == CHAR_DOLLAR) begin
            mode    = MODE_MATCH;
            tag_pos = 0;
        end
    endtask

    // Compare output transactions, then feed input transactions to the shadow parser
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode      = MODE_HUNT;
            tag_pos   = 0;
            cur_field = '0;
            cur_char  = '0;
            expected_fields.delete();
            pending_count   <= 0;
            predicted_count <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got.number = field_number;
                got.length = field_length;
                got.c0     = chars_zero_to_three;
                got.c4     = chars_four_to_seven;
                got.c8     = chars_eight_nine;
                got.last   = last_field;
                if (expected_fields.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected field: num=%0d len=%0d c0=%h c4=%h c8=%h last=%b",
                                 got.number, got.length, got.c0, got.c4, got.c8, got.last);
                    mismatches++;
                end
                else begin
                    want = expected_fields.pop_front();
                    if (got.number != want.number || got.length != want.length ||
                        got.c0 != want.c0 || got.c4 != want.c4 ||
                        got.c8 != want.c8 || got.last != want.last) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("field mismatch, expected: num=%0d len=%0d c0=%h c4=%h c8=%h last=%b",
                                     want.number, want.length, want.c0, want.c4, want.c8, want.last);
                            $display("                actual:   num=%0d len=%0d c0=%h c4=%h c8=%h last=%b",
                                     got.number, got.length, got.c0, got.c4, got.c8, got.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                split_byte(rx_byte);
            pending_count   <= expected_fields.size();
            predicted_count <= predicted_total;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the GGA field splitter: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import ngga_pkg::*;

    localparam int NUM_FIELDS   = 9;
    localparam int FIELD_CHARS  = 10;
    localparam int CLK_HALF     = 5;
    localparam int MIN_BYTES    = 220;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 300000;

    localparam logic [8*6-1:0]  GGA_TAG       = "GPGGA,";
    localparam logic [8*10-1:0] OPENING       = "$GP$GPGGA,";
    localparam logic [79:0]     EXTREME_CHARS = 80'h2D_23_AA_55_FE_01_7F_80_00_FF;

    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_OVERFLOW,
        FLAW_DOLLAR
    } sentence_flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  field_number;
    logic [3:0]  field_length;
    logic [31:0] chars_zero_to_three;
    logic [31:0] chars_four_to_seven;
    logic [15:0] chars_eight_nine;
    logic        last_field;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned predicted_count;

    bit          tx_eager;
    int unsigned bytes_sent;

    always #CLK_HALF clk = ~clk;

    nmea_gga_field_splitter #(
        .NUM_FIELDS  (NUM_FIELDS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .field_number        (field_number),
        .field_length        (field_length),
        .chars_zero_to_three (chars_zero_to_three),
        .chars_four_to_seven (chars_four_to_seven),
        .chars_eight_nine    (chars_eight_nine),
        .last_field          (last_field)
    );

    gga_checker #(
        .NUM_FIELDS  (NUM_FIELDS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .field_number        (field_number),
        .field_length        (field_length),
        .chars_zero_to_three (chars_zero_to_three),
        .chars_four_to_seven (chars_four_to_seven),
        .chars_eight_nine    (chars_eight_nine),
        .last_field          (last_field),
        .fail_count          (fail_count),
        .pending_count       (pending_count),
        .predicted_count     (predicted_count)
    );

    // Offer one byte after a random gap and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Any byte except the two delimiters
    function automatic logic [7:0] field_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CHAR_DOLLAR || b == CHAR_COMMA);
        return b;
    endfunction

    // Drop valid and wait until every predicted field has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Send one sentence, either clean or with a single flaw
    task automatic send_sentence(input sentence_flaw_t flaw);
        int bad_field;
        int bad_pos;
        int len;
        int cut;
        logic [7:0] tag_c;
        send_byte(CHAR_DOLLAR);
        if (flaw == FLAW_HEADER) begin
            bad_pos = $urandom_range(0, 5);
            for (int k = 0; k < bad_pos; k++)
                send_byte(GGA_TAG[8*(5-k) +: 8]);
            tag_c = GGA_TAG[8*(5-bad_pos) +: 8];
            if ($urandom_range(0, 1) == 0)
                send_byte(CHAR_DOLLAR);
            else
                send_byte(tag_c ^ 8'($urandom_range(1, 255)));
            return;
        end
        for (int k = 0; k < 6; k++)
            send_byte(GGA_TAG[8*(5-k) +: 8]);
        bad_field = $urandom_range(0, NUM_FIELDS - 1);
        for (int f = 0; f < NUM_FIELDS; f++) begin
            // mostly short fields keep sentences brief
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                              : $urandom_range(0, FIELD_CHARS);
            if (flaw == FLAW_OVERFLOW && f == bad_field)
                len = FIELD_CHARS + 1;
            cut = (flaw == FLAW_DOLLAR && f == bad_field) ? $urandom_range(0, len) : -1;
            for (int k = 0; k < len; k++) begin
                if (k == cut)
                    send_byte(CHAR_DOLLAR);
                send_byte(field_char());
            end
            if (cut == len)
                send_byte(CHAR_DOLLAR);
            send_byte(CHAR_COMMA);
        end
    endtask

    // Drain results with random stalls, and once hold off for a long stretch
    initial begin : result_drain
        int  wait_cycles;
        bit  held;
        bit  rx_eager;
        held      = 1'b0;
        rx_eager  = 1'b0;
        out_stall = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (!held && in_valid && pending_count != 0 && predicted_count >= NUM_FIELDS) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall) begin
                if ($urandom_range(0, 9) == 0)
                    rx_eager = !rx_eager;
                wait_cycles = rx_eager ? 0 : $urandom_range(0, 8);
                if (wait_cycles != 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // End the run if it hangs
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        int pick;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        tx_eager   = 1'b0;
        bytes_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: restart on a dollar in the header, a full-length field of
        // extreme characters, then eight empty fields
        for (int k = 0; k < 10; k++)
            send_byte(OPENING[8*(9-k) +: 8]);
        for (int k = 0; k < FIELD_CHARS; k++)
            send_byte(EXTREME_CHARS[8*k +: 8]);
        for (int f = 0; f < NUM_FIELDS; f++)
            send_byte(CHAR_COMMA);
        drain_results();

        // Random: mostly clean sentences, some noise and broken ones
        while (bytes_sent < MIN_BYTES) begin
            tx_eager = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    for (int k = $urandom_range(1, 6); k > 0; k--)
                        send_byte(8'($urandom_range(0, 255)));
                end
                1:       send_sentence(FLAW_HEADER);
                2:       send_sentence(FLAW_OVERFLOW);
                3:       send_sentence(FLAW_DOLLAR);
                default: send_sentence(FLAW_NONE);
            endcase
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
